@@ src/deadline_task_queue_macros.svh @@
// Assertion macros for the deadline task queue.
// Used by the controller and datapath files; needs clk and rst_n in scope.
`ifndef DEADLINE_TASK_QUEUE_MACROS_SVH
`define DEADLINE_TASK_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadline_task_queue: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadline_task_queue: next-cycle check failed");

`endif

@@ src/dtq_pkg.sv @@
// Shared types and constants of the deadline task queue.
// No dependencies; imported by the interface, controller, datapath and top-level files.
package dtq_pkg;

    localparam int DTQ_DEPTH_DEFAULT = 16;

    typedef logic [7:0]  tag_t;
    typedef logic [15:0] minutes_t;
    typedef logic [31:0] sec_t;
    typedef logic [4:0]  pend_t;

    typedef enum logic
    {
        CMD_ADD  = 1'b0,
        CMD_STEP = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0]
    {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_FIRED   = 3'd2,
        ST_WAITING = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // Controller to datapath commands.
    typedef struct packed
    {
        logic load;
        logic calc;
        logic exec;
        logic report;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed
    {
        logic out_busy;
    } dp_sts_t;

endpackage

@@ src/dtq_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on dtq_pkg for payload types.
interface dtq_req_if import dtq_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_code_t cmd;
    tag_t      task_tag;
    minutes_t  delay_minutes;

    modport source (output valid, cmd, task_tag, delay_minutes, input ready);
    modport sink   (input valid, cmd, task_tag, delay_minutes, output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    tag_t    fired_tag;
    sec_t    wait_seconds;
    pend_t   pending_count;
    tag_t    next_tag;
    sec_t    next_due;

    modport source (output valid, status, fired_tag, wait_seconds, pending_count,
                    next_tag, next_due, input ready);
    modport sink   (input valid, status, fired_tag, wait_seconds, pending_count,
                    next_tag, next_due, output ready);
endinterface

@@ src/dtq_ctrl.sv @@
// Sequencing state machine of the deadline task queue.
// Depends on dtq_pkg and deadline_task_queue_macros.svh.
`include "deadline_task_queue_macros.svh"

module dtq_ctrl import dtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CALC,
        S_EXEC,
        S_REPORT
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept     = req_valid && ready_reg;
    assign req_ready  = ready_reg;
    assign cmd.load   = accept;
    assign cmd.calc   = (state_reg == S_CALC);
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.report = (state_reg == S_REPORT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CALC;
                        ready_reg <= 1'b0;
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    // hold until the result register can take the beat
                    if (!sts.out_busy)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    `DTQ_ASSERT_IMPL(a_ready_only_idle, 1'b1, ready_reg == (state_reg == S_IDLE))
    `DTQ_ASSERT_NEXT(a_accept_to_calc, accept, state_reg == S_CALC)
    `DTQ_ASSERT_NEXT(a_exec_to_report, state_reg == S_EXEC, state_reg == S_REPORT)

endmodule

@@ src/dtq_dp.sv @@
// Datapath of the deadline task queue: clock, sorted cell row, result register.
// Depends on dtq_pkg and deadline_task_queue_macros.svh.
`include "deadline_task_queue_macros.svh"

module dtq_dp import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DTQ_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output dp_sts_t   sts,
    input  cmd_code_t req_cmd,
    input  tag_t      req_tag,
    input  minutes_t  req_minutes,
    output logic      out_valid,
    input  logic      out_ready,
    output status_t   out_status,
    output tag_t      out_fired_tag,
    output sec_t      out_wait_seconds,
    output pend_t     out_pending_count,
    output tag_t      out_next_tag,
    output sec_t      out_next_due
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // latched request
    cmd_code_t cmd_reg;
    tag_t      tag_reg;
    minutes_t  min_reg;
    sec_t      due_reg;

    // block state
    sec_t             now_reg;
    logic [CNT_W-1:0] cnt_reg;
    sec_t             cell_due [QUEUE_DEPTH];
    tag_t             cell_tag [QUEUE_DEPTH];
    sec_t             due_nx   [QUEUE_DEPTH];
    tag_t             tag_nx   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le;

    // per-item result
    status_t res_status_reg;
    tag_t    res_fired_reg;
    sec_t    res_wait_reg;

    logic    out_valid_reg;
    logic    out_busy;
    logic    full;
    logic    empty;
    logic    due_now;
    logic    ins_en;
    logic    rem_en;
    logic    load_out;
    logic [21:0] prod;
    logic [32:0] sum;

    // minutes * 60 as (m << 6) - (m << 2)
    assign prod    = {min_reg, 6'b0} - {2'b0, min_reg, 4'b0} / 22'd4;
    assign sum     = {1'b0, now_reg} + 33'(prod);

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign due_now = (now_reg >= cell_due[0]);
    assign ins_en  = cmd.exec && (cmd_reg == CMD_ADD) && !full;
    assign rem_en  = cmd.exec && (cmd_reg == CMD_STEP) && !empty && due_now;

    assign out_busy     = out_valid_reg && !out_ready;
    assign sts.out_busy = out_busy;
    assign load_out     = cmd.report && !out_busy;
    assign out_valid    = out_valid_reg;

    // each cell decides alone: keep, take the new task, or take a neighbor
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic prev_le;
        sec_t prev_due;
        tag_t prev_tag;
        sec_t succ_due;
        tag_t succ_tag;

        assign le[g] = (CNT_W'(g) < cnt_reg) && (cell_due[g] <= due_reg);

        if (g == 0)
        begin : g_first
            assign prev_le  = 1'b1;
            assign prev_due = cell_due[g];
            assign prev_tag = cell_tag[g];
        end
        else
        begin : g_mid
            assign prev_le  = le[g-1];
            assign prev_due = cell_due[g-1];
            assign prev_tag = cell_tag[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign succ_due = cell_due[g];
            assign succ_tag = cell_tag[g];
        end
        else
        begin : g_inner
            assign succ_due = cell_due[g+1];
            assign succ_tag = cell_tag[g+1];
        end

        always_comb
        begin
            due_nx[g] = cell_due[g];
            tag_nx[g] = cell_tag[g];
            if (ins_en)
            begin
                priority if (le[g])
                begin
                    due_nx[g] = cell_due[g];
                end
                else if (prev_le)
                begin
                    due_nx[g] = due_reg;
                    tag_nx[g] = tag_reg;
                end
                else
                begin
                    due_nx[g] = prev_due;
                    tag_nx[g] = prev_tag;
                end
            end
            else if (rem_en)
            begin
                due_nx[g] = succ_due;
                tag_nx[g] = succ_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_due[i] <= due_nx[i];
            cell_tag[i] <= tag_nx[i];
        end
    end

    // request latch and due time, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= req_cmd;
            tag_reg <= req_tag;
            min_reg <= req_minutes;
        end
        if (cmd.calc)
        begin
            due_reg <= sum[32] ? '1 : sum[31:0];
        end
    end

    // clock, count and result of the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (ins_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (rem_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            else if ((cmd_reg == CMD_STEP) && !empty)
            begin
                now_reg <= now_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_fired_reg <= '0;
            res_wait_reg  <= '0;
            priority if (cmd_reg == CMD_ADD)
            begin
                res_status_reg <= full ? ST_FULL : ST_ADDED;
            end
            else if (empty)
            begin
                res_status_reg <= ST_EMPTY;
            end
            else if (due_now)
            begin
                res_status_reg <= ST_FIRED;
                res_fired_reg  <= cell_tag[0];
            end
            else
            begin
                res_status_reg <= ST_WAITING;
                res_wait_reg   <= cell_due[0] - now_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status        <= res_status_reg;
            out_fired_tag     <= res_fired_reg;
            out_wait_seconds  <= res_wait_reg;
            out_pending_count <= 5'(cnt_reg);
            out_next_tag      <= empty ? '0 : cell_tag[0];
            out_next_due      <= empty ? '0 : cell_due[0];
        end
    end

    `DTQ_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `DTQ_ASSERT_IMPL(a_head_order, cnt_reg >= CNT_W'(2), cell_due[0] <= cell_due[1])
    `DTQ_ASSERT_NEXT(a_wait_advances,
        cmd.exec && (cmd_reg == CMD_STEP) && !empty && !due_now,
        now_reg == $past(now_reg) + 32'd1)

endmodule

@@ src/deadline_task_queue.sv @@
// Top level of the deadline task queue: controller plus datapath.
// Depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_dp.
//
//   channel | modport | beat carries
//   --------+---------+------------------------------------------------------
//   req     | sink    | cmd, task_tag, delay_minutes
//   rsp     | source  | status, fired_tag, wait_seconds, pending_count,
//           |         | next_tag, next_due
//
// Each request goes through accept, due-time calculation, queue update and
// result register load in that order, as sequenced by dtq_ctrl.
// A stalled rsp holds the sequencer in its report step; req.ready stays low until
// the result is loaded, and the next request may be accepted while that
// result still waits in the output register.
// Reset clears the seconds counter and the task count; the task cells need
// no clearing pass, since cells at or above the count never reach a result.
module deadline_task_queue import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DTQ_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    dtq_req_if.sink   req,
    dtq_rsp_if.source rsp
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // sequencer: owns req.ready and paces the datapath
    dtq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: clock, sorted task cells and result register
    dtq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_cmd           (req.cmd),
        .req_tag           (req.task_tag),
        .req_minutes       (req.delay_minutes),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_status        (rsp.status),
        .out_fired_tag     (rsp.fired_tag),
        .out_wait_seconds  (rsp.wait_seconds),
        .out_pending_count (rsp.pending_count),
        .out_next_tag      (rsp.next_tag),
        .out_next_due      (rsp.next_due)
    );

endmodule

@@ sim/tb_top.sv @@
// Testbench for deadline_task_queue: random and directed add/step beats,
// a scoreboard fed by an in-bench queue predictor, and random idling.
// Depends on dtq_pkg, dtq_if and the deadline_task_queue RTL.
`timescale 1ns / 100ps

module tb_top;
    import dtq_pkg::*;

    localparam int DEPTH       = DTQ_DEPTH_DEFAULT;
    localparam int N_ITEMS     = 1000;
    // Beats left in the plan below which neither side idles any more.
    localparam int QUIET_TAIL  = 120;
    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT  = 2000;
    // Tasks with a delay drawn from the whole 16-bit range never fire
    // within this run; cap them so they cannot jam the queue.
    localparam int LONG_BUDGET = 6;

    // One pending request beat. hold_for_drain keeps the beat back until
    // every earlier result has come out.
    typedef struct
    {
        cmd_code_t cmd;
        tag_t      tag;
        minutes_t  minutes;
        bit        hold_for_drain;
    } job_t;

    typedef struct packed
    {
        status_t status;
        tag_t    fired_tag;
        sec_t    wait_seconds;
        pend_t   pending_count;
        tag_t    next_tag;
        sec_t    next_due;
    } outcome_t;

    logic clk;
    logic rst_n;

    dtq_req_if req_ch ();
    dtq_rsp_if rsp_ch ();

    deadline_task_queue #(.QUEUE_DEPTH(DEPTH)) u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: the seconds counter and the task list sorted by due
    // time, earliest first. Only slots below n_queued are meaningful.
    // ------------------------------------------------------------------
    sec_t clock_sec = '0;
    int   n_queued  = 0;
    sec_t due_of [DEPTH];
    tag_t tag_of [DEPTH];

    job_t     plan [$];
    outcome_t expected_q [$];
    int       n_errors     = 0;
    int       long_left    = LONG_BUDGET;
    int       gap_left     = 0;
    int       stall_left   = 0;
    int       quiet_cycles = 0;

    // Work out the result of one accepted beat and advance the predictor.
    function automatic outcome_t schedule_outcome(cmd_code_t cmd, tag_t tag,
                                                  minutes_t minutes);
        outcome_t    o;
        logic [47:0] due_wide;
        sec_t        due;
        int          slot;
        o = '0;
        if (cmd == CMD_ADD)
        begin
            if (n_queued >= DEPTH)
            begin
                o.status = ST_FULL;
            end
            else
            begin
                // Saturate the due time at the top of the seconds range.
                due_wide = 48'(clock_sec) + 48'(minutes) * 48'd60;
                due = (due_wide > 48'hFFFF_FFFF) ? '1 : due_wide[31:0];
                // Insert behind every task due at the same time or earlier.
                slot = 0;
                while (slot < n_queued && due_of[slot] <= due)
                    slot++;
                for (int i = n_queued; i > slot; i--)
                begin
                    due_of[i] = due_of[i - 1];
                    tag_of[i] = tag_of[i - 1];
                end
                due_of[slot] = due;
                tag_of[slot] = tag;
                n_queued++;
                o.status = ST_ADDED;
            end
        end
        else if (n_queued == 0)
        begin
            o.status = ST_EMPTY;
        end
        else if (clock_sec >= due_of[0])
        begin
            o.status    = ST_FIRED;
            o.fired_tag = tag_of[0];
            for (int i = 1; i < n_queued; i++)
            begin
                due_of[i - 1] = due_of[i];
                tag_of[i - 1] = tag_of[i];
            end
            n_queued--;
        end
        else
        begin
            // Head not due yet: report the remaining seconds, tick the clock.
            o.status       = ST_WAITING;
            o.wait_seconds = due_of[0] - clock_sec;
            clock_sec++;
        end
        o.pending_count = pend_t'(n_queued);
        if (n_queued != 0)
        begin
            o.next_tag = tag_of[0];
            o.next_due = due_of[0];
        end
        return o;
    endfunction

    function automatic string outcome_str(outcome_t o);
        return $sformatf("status=%0d fired=%02h wait=%0d pend=%0d next=%02h due=%0d",
                         o.status, o.fired_tag, o.wait_seconds, o.pending_count,
                         o.next_tag, o.next_due);
    endfunction

    task automatic queue_job(cmd_code_t cmd, tag_t tag, minutes_t minutes);
        job_t j;
        j.cmd            = cmd;
        j.tag            = tag;
        j.minutes        = minutes;
        j.hold_for_drain = 1'b0;
        plan.push_back(j);
    endtask

    // Mostly zero or one minute so tasks actually fire within the run;
    // a handful of full-range delays exercise the upper bits.
    function automatic minutes_t pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return '0;
        if (r < 85)
            return minutes_t'(1);
        if (r < 95)
            return minutes_t'($urandom_range(2, 5));
        if (long_left > 0)
        begin
            long_left--;
            return minutes_t'($urandom_range(0, 65535));
        end
        return '0;
    endfunction

    // ------------------------------------------------------------------
    // Clock and the single reset pulse. Drive every block input to a known
    // value at time zero, before the first edge.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ADD;
        req_ch.task_tag      = '0;
        req_ch.delay_minutes = '0;
        rsp_ch.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus plan. Fill it in zero time, so it is complete before the
    // driver sees its first edge out of reset.
    // ------------------------------------------------------------------
    initial
    begin
        int n_add;
        int n_step;

        // Step on an empty queue: nothing fires, the clock stays put.
        queue_job(CMD_STEP, 8'h00, 16'h0000);
        // Longest delay with every tag bit set; this task parks at the
        // tail for the whole run. Due-time saturation needs a clock near
        // the top of its range and cannot be reached in a run this short.
        queue_job(CMD_ADD, 8'hFF, 16'hFFFF);
        // Zero delay with every bit clear: due at once, fires on the step.
        queue_job(CMD_ADD, 8'h00, 16'h0000);
        queue_job(CMD_STEP, 8'h00, 16'h0000);
        // Head is now the long task: waiting, clock ticks to one.
        queue_job(CMD_STEP, 8'h00, 16'h0000);
        // Two tasks due at the same second must fire in insertion order.
        queue_job(CMD_ADD, 8'hA5, 16'h0001);
        queue_job(CMD_ADD, 8'h5A, 16'h0001);
        queue_job(CMD_STEP, 8'h00, 16'h0000);
        // Fill the queue with equal-due tasks, then overflow it once.
        for (int i = 0; i < DEPTH - 3; i++)
            queue_job(CMD_ADD, tag_t'(8'h10 + i), 16'h0000);
        queue_job(CMD_ADD, 8'h77, 16'h0002);

        // Random part: mostly well-formed bursts of adds followed by runs
        // of steps; the rest is noise with random commands.
        while (plan.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                    : $urandom_range(1, 6);
                for (int i = 0; i < n_add; i++)
                    queue_job(CMD_ADD, tag_t'($urandom_range(0, 255)), pick_delay());
                n_step = $urandom_range(1, 24);
                for (int i = 0; i < n_step; i++)
                    queue_job(CMD_STEP, tag_t'($urandom_range(0, 255)),
                              minutes_t'($urandom_range(0, 65535)));
            end
            else
            begin
                n_add = $urandom_range(1, 8);
                for (int i = 0; i < n_add; i++)
                    queue_job(cmd_code_t'($urandom_range(0, 1)),
                              tag_t'($urandom_range(0, 255)), pick_delay());
            end
        end

        // Hold the sender once in mid-run until the response side is empty.
        plan[plan.size() / 2].hold_for_drain = 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver. Predict on the accepted beat, then present the next
    // one unless a gap burst, a drain hold or an empty plan says idle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.cmd           <= CMD_ADD;
            req_ch.task_tag      <= '0;
            req_ch.delay_minutes <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_q.push_back(schedule_outcome(req_ch.cmd, req_ch.task_tag,
                                                      req_ch.delay_minutes));
            // Hold the payload while the current beat is still waiting.
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (plan.size() == 0 ||
                         (plan[0].hold_for_drain && expected_q.size() != 0))
                begin
                    req_ch.valid <= 1'b0;
                end
                else if (plan.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 16) - 1;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.valid         <= 1'b1;
                    req_ch.cmd           <= plan[0].cmd;
                    req_ch.task_tag      <= plan[0].tag;
                    req_ch.delay_minutes <= plan[0].minutes;
                    plan.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor. Check each accepted beat against the oldest
    // expectation, then drop ready in random stall bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status        = rsp_ch.status;
                got.fired_tag     = rsp_ch.fired_tag;
                got.wait_seconds  = rsp_ch.wait_seconds;
                got.pending_count = rsp_ch.pending_count;
                got.next_tag      = rsp_ch.next_tag;
                got.next_due      = rsp_ch.next_due;
                if (expected_q.size() == 0)
                begin
                    if (n_errors < 10)
                        $display("%0t: result with nothing expected: %s",
                                 $realtime, outcome_str(got));
                    n_errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.fired_tag !== want.fired_tag ||
                        got.wait_seconds !== want.wait_seconds ||
                        got.pending_count !== want.pending_count ||
                        got.next_tag !== want.next_tag || got.next_due !== want.next_due)
                    begin
                        if (n_errors < 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, outcome_str(want), outcome_str(got));
                        n_errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (plan.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either side for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= HANG_LIMIT)
                begin
                    $display("FAIL deadline_task_queue");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run: wait for the plan to go out and every result to come
    // back, let the pipeline settle, then report.
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        while (plan.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (n_errors == 0)
            $display("PASS deadline_task_queue");
        else
            $display("FAIL deadline_task_queue");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/dtq_pkg.sv
src/dtq_if.sv
src/dtq_ctrl.sv
src/dtq_dp.sv
src/deadline_task_queue.sv
sim/tb_top.sv
